// ----- design/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Constants, codes and helpers for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int CELL_AW = $clog2(CELLS);
	localparam int IDX_W   = $clog2(CELLS + 1);

	localparam int CMD_W    = 2;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 40;
	localparam int ADDR_W   = 3;
	localparam int APB_DW   = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] ATTR_RESET = 8'h0F;

	function automatic logic [CELL_AW-1:0] cell_addr(input logic [ROW_W-1:0] row,
	                                                 input logic [COL_W-1:0] col);
		logic [CELL_AW+ROW_W:0] prod;
		prod = (CELL_AW+ROW_W+1)'(row) * (CELL_AW+ROW_W+1)'(COLUMNS)
		       + (CELL_AW+ROW_W+1)'(col);
		return prod[CELL_AW-1:0];
	endfunction

endpackage

// ----- design/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell screen store with cursor, scroll, clear, cell read and
// serial echo, run by a small sequencer over one single-port-write store.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Payload
// s_*       in   tvalid/tready      tuser: cmd; tdata: char_code, read_column, read_row
// m_*       out  tvalid/tready      tdata: echo, cell, cursor; tlast: last
// APB       in   psel/penable       text_attributes at byte address 0
//
// A plain write, carriage return, out-of-range read or unused command passes
// through ST_EXEC and ST_EMIT; an in-range read adds ST_READ, a newline ST_EMIT2.
// A newline on the bottom row, or a write that wraps past it, walks the store
// once in ST_SCROLL; a clear walks it once in ST_CLEAR. After reset the store is
// filled with spaces, one cell a cycle, and no item is taken until then. An
// output stall holds the emit states until the output is free; the next item is
// taken while a result still waits.
// ----------------------------------------------------------------------------
module text_console_writer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [7:0] char_code, [14:8] read_column, [19:15] read_row
	input  logic [tcw_pkg::S_DATA_W-1:0]  s_tdata,
	// [1:0] cmd
	input  logic [tcw_pkg::CMD_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [0] serial_valid, [8:1] serial_byte, [16:9] cell_char, [24:17] cell_attr,
	// [31:25] cursor_column, [36:32] cursor_row
	output logic [tcw_pkg::M_DATA_W-1:0]  m_tdata,
	output logic                          m_tlast,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tcw_pkg::ADDR_W-1:0]    paddr,
	input  logic [tcw_pkg::APB_DW-1:0]    pwdata,
	output logic [tcw_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);
	import tcw_pkg::*;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_SCROLL,
		ST_CLEAR,
		ST_READ,
		ST_EMIT,
		ST_EMIT2
	} state_t;

	state_t             state_q;
	logic [7:0]         attr_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [IDX_W-1:0]   idx_q;
	logic               scr_v_s1;
	logic               scr_top_s1;
	logic [CELL_AW-1:0] scr_addr_s1;

	logic [CMD_W-1:0]   cmd_q;
	logic [7:0]         ch_q;
	logic [COL_W-1:0]   rcol_q;
	logic [ROW_W-1:0]   rrow_q;

	logic               res_sv_q;
	logic [7:0]         res_sb_q;
	logic [7:0]         res_char_q;
	logic [7:0]         res_attr_q;
	logic               res_nl_q;

	logic               m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;
	logic               m_tlast_q;

	logic [15:0]        cells_q [CELLS];
	logic [15:0]        rd_q;

	logic               mem_we;
	logic [CELL_AW-1:0] mem_wa;
	logic [15:0]        mem_wd;
	logic [CELL_AW-1:0] mem_ra;

	logic               out_free;
	logic               emit_go;
	logic               rd_in_range;
	logic               col_wrap;
	logic               row_bottom;
	logic               scr_shift;
	logic               cfg_wr;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite & pready;
	assign prdata   = (paddr[2] == 1'b0) ? APB_DW'(attr_q) : '0;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign emit_go  = ((state_q == ST_EMIT) || (state_q == ST_EMIT2)) && out_free;

	assign rd_in_range = ({1'b0, rcol_q} < (COL_W+1)'(COLUMNS)) &&
	                     ({1'b0, rrow_q} < (ROW_W+1)'(ROWS));
	assign col_wrap    = ({1'b0, col_q} + (COL_W+1)'(1)) == (COL_W+1)'(COLUMNS);
	assign row_bottom  = ({1'b0, row_q} + (ROW_W+1)'(1)) == (ROW_W+1)'(ROWS);
	assign scr_shift   = idx_q < IDX_W'(CELLS - COLUMNS);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q[CELL_AW-1:0];
		mem_wd = {attr_q, CH_SPACE};
		mem_ra = cell_addr(rrow_q, rcol_q);
		case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				mem_wd = {ATTR_RESET, CH_SPACE};
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_EXEC: begin
				if (cmd_q == CMD_WRITE && ch_q != CH_LF && ch_q != CH_CR) begin
					mem_we = 1'b1;
					mem_wa = cell_addr(row_q, col_q);
					mem_wd = {attr_q, ch_q};
				end
			end
			ST_SCROLL: begin
				mem_ra = scr_shift ? CELL_AW'(idx_q + IDX_W'(COLUMNS))
				                   : idx_q[CELL_AW-1:0];
				mem_we = scr_v_s1;
				mem_wa = scr_addr_s1;
				mem_wd = scr_top_s1 ? rd_q : {rd_q[15:8], CH_SPACE};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cells_q[mem_wa] <= mem_wd;
		end
		rd_q <= cells_q[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			attr_q     <= ATTR_RESET;
			col_q      <= '0;
			row_q      <= '0;
			idx_q      <= '0;
			scr_v_s1   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr && paddr[2] == 1'b0) begin
				attr_q <= pwdata[7:0];
			end
			if (emit_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					if (idx_q == IDX_W'(CELLS - 1)) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= s_tuser;
						ch_q    <= s_tdata[7:0];
						rcol_q  <= s_tdata[14:8];
						rrow_q  <= s_tdata[19:15];
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					res_sv_q   <= (cmd_q == CMD_WRITE) && (ch_q != CH_CR);
					res_sb_q   <= (cmd_q != CMD_WRITE || ch_q == CH_CR) ? 8'h00 :
					              (ch_q == CH_LF) ? CH_CR : ch_q;
					res_nl_q   <= (cmd_q == CMD_WRITE) && (ch_q == CH_LF);
					res_char_q <= '0;
					res_attr_q <= '0;
					idx_q      <= '0;
					case (cmd_q)
						CMD_WRITE: begin
							if (ch_q == CH_LF || (ch_q != CH_CR && col_wrap)) begin
								col_q <= '0;
								if (row_bottom) begin
									state_q <= ST_SCROLL;
								end else begin
									row_q   <= row_q + ROW_W'(1);
									state_q <= ST_EMIT;
								end
							end else begin
								if (ch_q != CH_CR) begin
									col_q <= col_q + COL_W'(1);
								end
								state_q <= ST_EMIT;
							end
						end
						CMD_CLEAR: begin
							state_q <= ST_CLEAR;
						end
						CMD_READ: begin
							state_q <= rd_in_range ? ST_READ : ST_EMIT;
						end
						default: begin
							state_q <= ST_EMIT;
						end
					endcase
				end
				ST_READ: begin
					res_char_q <= rd_q[7:0];
					res_attr_q <= rd_q[15:8];
					state_q    <= ST_EMIT;
				end
				ST_SCROLL: begin
					if (idx_q == IDX_W'(CELLS)) begin
						scr_v_s1 <= 1'b0;
						state_q  <= ST_EMIT;
					end else begin
						scr_v_s1    <= 1'b1;
						scr_top_s1  <= scr_shift;
						scr_addr_s1 <= idx_q[CELL_AW-1:0];
						idx_q       <= idx_q + IDX_W'(1);
					end
				end
				ST_CLEAR: begin
					if (idx_q == IDX_W'(CELLS - 1)) begin
						idx_q   <= '0;
						col_q   <= '0;
						row_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tdata_q  <= {3'b000, row_q, col_q, res_attr_q, res_char_q,
						               res_sb_q, res_sv_q};
						m_tlast_q  <= !res_nl_q;
						state_q    <= res_nl_q ? ST_EMIT2 : ST_IDLE;
					end
				end
				ST_EMIT2: begin
					if (out_free) begin
						m_tdata_q  <= {3'b000, row_q, col_q, 8'h00, 8'h00, CH_LF, 1'b1};
						m_tlast_q  <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
